### design/positional_ordered_list_assert.svh
// assertion macros for the positional ordered list design
// no dependencies; the asserting modules take this file by include
`ifndef POSITIONAL_ORDERED_LIST_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_ASSERT_SVH
`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define POL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// condition that must never hold outside reset
`define POL_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define POL_ASSERT(name, clk, rst_n, prop)
`define POL_ASSERT_NEVER(name, clk, rst_n, cond)
`endif
`endif

### design/pol_pkg.sv
// types, codes and sizes shared by the positional ordered list design
// no dependencies
package pol_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned PosW     = 7;
  localparam int unsigned ValW     = 32;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned CmpW     = (PosW > CntW) ? PosW : CntW;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_RETRIEVE = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } back_op_e;

  typedef struct packed {
    logic [1:0]             action;
    logic [PosW-1:0]        position;
    logic signed [ValW-1:0] item;
  } req_t;

  typedef struct packed {
    logic signed [ValW-1:0] read_value;
    logic [SizeW-1:0]       list_size;
    logic [1:0]             status;
  } rsp_t;

  typedef struct packed {
    back_op_e               op;
    logic [IdxW-1:0]        idx;
    logic signed [ValW-1:0] item;
    logic [SizeW-1:0]       size;
    status_e                status;
  } cmd_t;

endpackage

### design/positional_ordered_list.sv
// top level of the positional ordered list: front end, command queue, cell row
// depends on pol_pkg, pol_front, pol_cmd_queue and pol_back
//
//  channel   | direction | handshake           | payload
//  request   | in        | push / full         | req_i  (action, position, item)
//  response  | out       | empty / pop         | rsp_o  (read_value, list_size, status)
//
// one transaction per cycle in both directions while the queue has room and
// responses are popped; an accepted request is written into the queue, then
// taken into the cell row and response register unless a held response stalls it
// the front end tracks the size and settles the status on acceptance, so the
// cell row only shifts or reads; each insert or remove shifts, at once, all
// cells from its position up; reset clears the size, queue and response valid;
// cell contents stay as they are and are only read below the current size
// full rises when the two-entry command queue fills behind a held response
module positional_ordered_list import pol_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  req_t req_i,
  output logic empty,
  input  logic pop,
  output rsp_t rsp_o
);

  logic accept;
  cmd_t front_cmd, queue_cmd;
  logic q_full, q_empty, q_take;

  // request transaction taken when the queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  // classification and size tracking
  pol_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .req_i   (req_i),
    .cmd_o   (front_cmd)
  );

  // decouples classification from the cell row
  pol_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (accept),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .rd_i   (q_take),
    .empty_o(q_empty),
    .cmd_o  (queue_cmd)
  );

  // cell row and response register
  pol_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!q_empty),
    .cmd_i      (queue_cmd),
    .cmd_take_o (q_take),
    .empty_o    (empty),
    .pop_i      (pop),
    .rsp_o      (rsp_o)
  );

endmodule

### design/pol_front.sv
// front end: takes requests, checks them against the running size
// and turns them into commands; depends on pol_pkg and the assert header
`include "positional_ordered_list_assert.svh"

module pol_front import pol_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  req_t req_i,
  output cmd_t cmd_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CmpW-1:0] pos_ext, cnt_ext;
  logic            is_full;

  assign pos_ext = CmpW'(req_i.position);
  assign cnt_ext = CmpW'(cnt_q);
  assign is_full = (cnt_q == CntW'(CAPACITY));

  always_comb begin
    cnt_d       = cnt_q;
    cmd_o.op    = OP_NONE;
    cmd_o.idx   = IdxW'(req_i.position);
    cmd_o.item  = req_i.item;
    cmd_o.status = ST_RANGE;
    unique case (req_i.action)
      ACT_INSERT: begin
        if (pos_ext > cnt_ext) begin
          cmd_o.status = ST_RANGE;
        end else if (is_full) begin
          cmd_o.status = ST_FULL;
        end else begin
          cmd_o.op     = OP_INSERT;
          cmd_o.status = ST_OK;
          cnt_d        = cnt_q + CntW'(1);
        end
      end
      ACT_REMOVE: begin
        if (pos_ext < cnt_ext) begin
          cmd_o.op     = OP_REMOVE;
          cmd_o.status = ST_OK;
          cnt_d        = cnt_q - CntW'(1);
        end
      end
      ACT_RETRIEVE: begin
        if (pos_ext < cnt_ext) begin
          cmd_o.op     = OP_READ;
          cmd_o.status = ST_OK;
        end
      end
      default: begin
        cmd_o.status = ST_RANGE;
      end
    endcase
    // size reported after this access
    cmd_o.size = SizeW'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  `POL_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(CAPACITY))
  `POL_ASSERT(a_reject_keeps_cnt, clk_i, rst_ni,
              (accept_i && cmd_o.status != ST_OK) |=> $stable(cnt_q))

endmodule

### design/pol_cmd_queue.sv
// two-entry command queue between the front end and the cell row
// depends on pol_pkg
module pol_cmd_queue import pol_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic rd_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;

  assign full_o  = (fill_q == 2'd2);
  assign empty_o = (fill_q == 2'd0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (wr_i && !rd_i) begin
        fill_q <= fill_q + 2'd1;
      end else if (rd_i && !wr_i) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

endmodule

### design/pol_back.sv
// back end: row of item cells that shift in parallel, plus result register
// depends on pol_pkg and the assert header
`include "positional_ordered_list_assert.svh"

module pol_back import pol_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_take_o,
  output logic empty_o,
  input  logic pop_i,
  output rsp_t rsp_o
);

  logic signed [ValW-1:0] cell_q [CAPACITY];
  logic                   rsp_valid_q;
  rsp_t                   rsp_q, rsp_d;
  logic                   do_ins, do_rem;

  assign cmd_take_o = cmd_valid_i && (!rsp_valid_q || pop_i);
  assign do_ins     = cmd_take_o && (cmd_i.op == OP_INSERT);
  assign do_rem     = cmd_take_o && (cmd_i.op == OP_REMOVE);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ValW-1:0] prev_val, next_val;

    if (i > 0) begin : g_prev
      assign prev_val = cell_q[i-1];
    end else begin : g_noprev
      assign prev_val = cell_q[i];
    end
    if (i < CAPACITY - 1) begin : g_next
      assign next_val = cell_q[i+1];
    end else begin : g_nonext
      assign next_val = cell_q[i];
    end

    always_ff @(posedge clk_i) begin
      if (do_ins) begin
        if (IdxW'(i) > cmd_i.idx) begin
          cell_q[i] <= prev_val;
        end else if (IdxW'(i) == cmd_i.idx) begin
          cell_q[i] <= cmd_i.item;
        end
      end else if (do_rem) begin
        if (IdxW'(i) >= cmd_i.idx) begin
          cell_q[i] <= next_val;
        end
      end
    end
  end

  always_comb begin
    rsp_d.read_value = '0;
    if (cmd_i.op == OP_READ) begin
      rsp_d.read_value = cell_q[cmd_i.idx];
    end
    rsp_d.list_size = cmd_i.size;
    rsp_d.status    = cmd_i.status;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_take_o) begin
      rsp_valid_q <= 1'b1;
    end else if (pop_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  assign empty_o = !rsp_valid_q;
  assign rsp_o   = rsp_q;

  `POL_ASSERT(a_insert_lands, clk_i, rst_ni,
              do_ins |=> (cell_q[$past(cmd_i.idx)] == $past(cmd_i.item)))
  `POL_ASSERT_NEVER(a_reject_value, clk_i, rst_ni,
                    rsp_valid_q && rsp_q.status != ST_OK && rsp_q.read_value != '0)

endmodule
